// ===== hdl/scs_pkg.sv =====
package scs_pkg;

  localparam int SCS_MAX_TAPS    = 3;
  localparam int SCS_COORD_WIDTH = 16;

  localparam int TAP_W        = 8;
  localparam int LEN_W        = 2;
  localparam int STENCIL_TAPS = 3;
  // A tap sum of three 8-bit weights needs two more bits.
  localparam int DEN_W        = TAP_W + 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_TAP_FIRST  = 3'd0,
    REG_A_TAP_SECOND = 3'd1,
    REG_A_TAP_THIRD  = 3'd2,
    REG_A_LENGTH     = 3'd3,
    REG_B_TAP_FIRST  = 3'd4,
    REG_B_TAP_SECOND = 3'd5,
    REG_B_TAP_THIRD  = 3'd6,
    REG_B_LENGTH     = 3'd7
  } scs_reg_idx_t;

  typedef logic signed [TAP_W-1:0] scs_tap_t;

  typedef struct packed {
    scs_tap_t [STENCIL_TAPS-1:0] taps;
    logic [LEN_W-1:0]            len;
  } scs_stencil_t;

  localparam scs_stencil_t RST_STENCIL_A = '{taps: '{8'sd0, 8'sd4, 8'sd4}, len: 2'd2};
  localparam scs_stencil_t RST_STENCIL_B = '{taps: '{8'sd1, 8'sd6, 8'sd1}, len: 2'd3};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_point;
    logic       end_net;
    logic       mac_clear;
    logic       mac_step;
    logic       sel_b;
    logic [1:0] tap_k;
    logic [1:0] win_pos;
    logic       div_start;
    logic       out_pass;
    logic       out_result;
    logic       run_end;
  } scs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] seen_clip;
    logic       den_zero;
    logic       div_busy;
    logic       out_free;
  } scs_status_t;

endpackage

// ===== hdl/scs_point_if.sv =====
interface scs_point_if import scs_pkg::*; #(
  parameter int COORD_WIDTH = SCS_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink   (input valid, point_x, point_y, final_point, output ready);
endinterface

// ===== hdl/scs_result_if.sv =====
interface scs_result_if import scs_pkg::*; #(
  parameter int COORD_WIDTH = SCS_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic                          zero_sum;
  logic                          run_end;

  modport source (output valid, out_x, out_y, zero_sum, run_end, input ready);
  modport sink   (input valid, out_x, out_y, zero_sum, run_end, output ready);
endinterface

// ===== hdl/scs_cfg_if.sv =====
interface scs_cfg_if import scs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/scs_div.sv =====
module scs_div import scs_pkg::*; #(
  parameter int COORD_WIDTH = SCS_COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [COORD_WIDTH+DEN_W-1:0]   num,
  input  logic signed [DEN_W-1:0]               den,
  output logic                                  busy,
  output logic signed [COORD_WIDTH-1:0]         quot
);

  localparam int NUM_W = COORD_WIDTH + DEN_W;
  localparam int CNT_W = $clog2(COORD_WIDTH);

  logic [NUM_W-1:0]       an;
  logic [DEN_W-1:0]       ad;
  logic [NUM_W-1:0]       dividend;
  logic [NUM_W-1:0]       ad_hi;
  logic                   ovf;

  logic [DEN_W-1:0]       rem_r, rem_nxt;
  logic [COORD_WIDTH-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0]       ad_r, ad_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sat_r, sat_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;

  logic [DEN_W:0]         trial;
  logic [DEN_W:0]         ad_ext;
  logic                   ge;

  logic signed [COORD_WIDTH-1:0] pos_val;
  logic signed [COORD_WIDTH-1:0] neg_val;
  logic                          pos_big;
  logic                          neg_big;

  // Rounding to nearest is folded in by adding half the divisor up front.
  assign an       = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign ad       = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
  assign dividend = an + NUM_W'(ad >> 1);
  assign ad_hi    = {ad, {COORD_WIDTH{1'b0}}};
  // A quotient of 2**COORD_WIDTH or more saturates whatever its sign.
  assign ovf      = (dividend >= ad_hi);

  assign trial  = {rem_r, quo_r[COORD_WIDTH-1]};
  assign ad_ext = {1'b0, ad_r};
  assign ge     = (trial >= ad_ext);

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ad_nxt   = ad_r;
    neg_nxt  = neg_r;
    sat_nxt  = sat_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = dividend[NUM_W-1:COORD_WIDTH];
      quo_nxt  = dividend[COORD_WIDTH-1:0];
      ad_nxt   = ad;
      neg_nxt  = num[NUM_W-1] ^ den[DEN_W-1];
      sat_nxt  = ovf;
      cnt_nxt  = CNT_W'(COORD_WIDTH - 1);
      busy_nxt = !ovf;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(trial - ad_ext) : DEN_W'(trial);
      quo_nxt = {quo_r[COORD_WIDTH-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ad_r  <= ad_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
    cnt_r <= cnt_nxt;
  end

  assign pos_big = sat_r || quo_r[COORD_WIDTH-1];
  assign neg_big = sat_r || (quo_r[COORD_WIDTH-1] && (quo_r[COORD_WIDTH-2:0] != '0));
  assign pos_val = pos_big ? {1'b0, {(COORD_WIDTH-1){1'b1}}} : quo_r;
  assign neg_val = neg_big ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : -quo_r;

  assign quot = neg_r ? neg_val : pos_val;
  assign busy = busy_r;

endmodule

// ===== hdl/scs_dp.sv =====
module scs_dp import scs_pkg::*; #(
  parameter int MAX_TAPS    = SCS_MAX_TAPS,
  parameter int COORD_WIDTH = SCS_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scs_cmd_t                      cmd,
  output scs_status_t                   status,
  input  scs_tap_t [STENCIL_TAPS-1:0]   taps_a,
  input  scs_tap_t [STENCIL_TAPS-1:0]   taps_b,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_zero_sum,
  output logic                          out_run_end
);

  localparam int IW    = $clog2(MAX_TAPS);
  localparam int SW    = $clog2(MAX_TAPS + 1);
  localparam int NUM_W = COORD_WIDTH + DEN_W;
  localparam int PRD_W = COORD_WIDTH + TAP_W;

  logic signed [COORD_WIDTH-1:0] win_x_r [MAX_TAPS];
  logic signed [COORD_WIDTH-1:0] win_y_r [MAX_TAPS];
  logic signed [COORD_WIDTH-1:0] win_x_nxt [MAX_TAPS];
  logic signed [COORD_WIDTH-1:0] win_y_nxt [MAX_TAPS];
  logic [SW-1:0]                 seen_r, seen_nxt;

  logic signed [NUM_W-1:0]       acc_x_r, acc_x_nxt;
  logic signed [NUM_W-1:0]       acc_y_r, acc_y_nxt;
  logic signed [DEN_W-1:0]       den_r, den_nxt;

  scs_tap_t                      tap;
  logic [IW-1:0]                 win_idx;
  logic signed [COORD_WIDTH-1:0] wx;
  logic signed [COORD_WIDTH-1:0] wy;
  logic signed [PRD_W-1:0]       prod_x;
  logic signed [PRD_W-1:0]       prod_y;

  logic signed [COORD_WIDTH-1:0] q_x;
  logic signed [COORD_WIDTH-1:0] q_y;
  logic                          busy_x;
  logic                          busy_y;
  logic                          den_zero;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_x_nxt;
  logic signed [COORD_WIDTH-1:0] out_y_r, out_y_nxt;
  logic                          zs_r, zs_nxt;
  logic                          re_r, re_nxt;
  logic                          out_free;

  function automatic scs_tap_t tap_of(scs_tap_t [STENCIL_TAPS-1:0] t, logic [1:0] k);
    case (k)
      2'd0:    return t[0];
      2'd1:    return t[1];
      default: return t[2];
    endcase
  endfunction

  // Window shift line, newest point at entry zero.
  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      win_x_nxt[i] = win_x_r[i];
      win_y_nxt[i] = win_y_r[i];
    end
    if (cmd.load_point) begin
      win_x_nxt[0] = in_point_x;
      win_y_nxt[0] = in_point_y;
      for (int i = 1; i < MAX_TAPS; i++) begin
        win_x_nxt[i] = win_x_r[i-1];
        win_y_nxt[i] = win_y_r[i-1];
      end
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    if (cmd.end_net) begin
      seen_nxt = '0;
    end else if (cmd.load_point && (int'(seen_r) < MAX_TAPS)) begin
      seen_nxt = seen_r + SW'(1);
    end
  end

  // One tap per cycle into the multiply-accumulate.
  assign tap     = cmd.sel_b ? tap_of(taps_b, cmd.tap_k) : tap_of(taps_a, cmd.tap_k);
  assign win_idx = IW'(cmd.win_pos);
  assign wx      = win_x_r[win_idx];
  assign wy      = win_y_r[win_idx];
  assign prod_x  = wx * tap;
  assign prod_y  = wy * tap;

  always_comb begin
    acc_x_nxt = acc_x_r;
    acc_y_nxt = acc_y_r;
    den_nxt   = den_r;
    if (cmd.mac_clear) begin
      acc_x_nxt = '0;
      acc_y_nxt = '0;
      den_nxt   = '0;
    end else if (cmd.mac_step) begin
      acc_x_nxt = acc_x_r + NUM_W'(prod_x);
      acc_y_nxt = acc_y_r + NUM_W'(prod_y);
      den_nxt   = den_r + DEN_W'(tap);
    end
  end

  assign den_zero = (den_r == '0);

  scs_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_x_r),
    .den   (den_r),
    .busy  (busy_x),
    .quot  (q_x)
  );

  scs_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (acc_y_r),
    .den   (den_r),
    .busy  (busy_y),
    .quot  (q_y)
  );

  // Output register: a result may wait here while the controller goes on.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    zs_nxt        = zs_r;
    re_nxt        = re_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_pass) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = win_x_r[0];
      out_y_nxt     = win_y_r[0];
      zs_nxt        = 1'b0;
      re_nxt        = cmd.run_end;
    end else if (cmd.out_result) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = den_zero ? '0 : q_x;
      out_y_nxt     = den_zero ? '0 : q_y;
      zs_nxt        = den_zero;
      re_nxt        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      win_x_r[i] <= win_x_nxt[i];
      win_y_r[i] <= win_y_nxt[i];
    end
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
    den_r   <= den_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    zs_r    <= zs_nxt;
    re_r    <= re_nxt;
  end

  assign status.seen_clip = (int'(seen_r) > 3) ? 2'd3 : 2'(seen_r);
  assign status.den_zero  = den_zero;
  assign status.div_busy  = busy_x | busy_y;
  assign status.out_free  = out_free;

  assign out_valid    = out_valid_r;
  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_zero_sum = zs_r;
  assign out_run_end  = re_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_pass || cmd.out_result) |-> out_free)
    else $error("result loaded over an untaken transaction");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !(busy_x || busy_y))
    else $error("divider started while busy");

endmodule

// ===== hdl/scs_ctrl.sv =====
module scs_ctrl import scs_pkg::*; #(
  parameter int MAX_TAPS = SCS_MAX_TAPS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_final,
  output logic             in_ready,
  input  logic [LEN_W-1:0] len_a,
  input  logic [LEN_W-1:0] len_b,
  input  scs_status_t      status,
  output scs_cmd_t         cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PLAN  = 7'b0000010,
    S_PICK  = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_DIVGO = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  // Result jobs of one point, in emission order.
  localparam int NUM_SLOTS = 8;
  localparam logic [2:0] SLOT_FIRST   = 3'd0;
  localparam logic [2:0] SLOT_A_MAIN  = 3'd1;
  localparam logic [2:0] SLOT_B_MAIN  = 3'd2;
  localparam logic [2:0] SLOT_A_TAIL1 = 3'd3;
  localparam logic [2:0] SLOT_B_TAIL1 = 3'd4;
  localparam logic [2:0] SLOT_A_TAIL0 = 3'd5;
  localparam logic [2:0] SLOT_B_TAIL0 = 3'd6;
  localparam logic [2:0] SLOT_LAST    = 3'd7;

  state_t                 state_r, state_nxt;
  logic                   first_r, first_nxt;
  logic                   final_r, final_nxt;
  logic [NUM_SLOTS-1:0]   pend_r, pend_nxt;
  logic                   sel_b_r, sel_b_nxt;
  logic [1:0]             d_r, d_nxt;
  logic [1:0]             u_r, u_nxt;
  logic [1:0]             k_r, k_nxt;

  logic [LEN_W-1:0]       ua, ub, sa, sb, m;
  logic [NUM_SLOTS-1:0]   plan;
  logic [NUM_SLOTS-1:0]   lowest;
  logic [2:0]             cur_slot;
  logic                   job_pass;
  logic                   job_b;
  logic [1:0]             job_d;

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] l);
    if (int'(l) > MAX_TAPS) begin
      return LEN_W'(MAX_TAPS);
    end
    return l;
  endfunction

  assign ua = clamp_len(len_a);
  assign ub = clamp_len(len_b);
  assign sa = (ua == '0) ? LEN_W'(1) : ua;
  assign sb = (ub == '0) ? LEN_W'(1) : ub;
  assign m  = (sa > sb) ? sa : sb;

  // Evaluated in the cycle after the point is taken, so seen_clip is updated.
  always_comb begin
    plan               = '0;
    plan[SLOT_FIRST]   = first_r;
    plan[SLOT_A_MAIN]  = (status.seen_clip >= m);
    plan[SLOT_B_MAIN]  = (status.seen_clip >= m);
    plan[SLOT_A_TAIL1] = final_r && (m == 2'd3) && (status.seen_clip > 2'd1) && (sa <= 2'd2);
    plan[SLOT_B_TAIL1] = final_r && (m == 2'd3) && (status.seen_clip > 2'd1) && (sb <= 2'd2);
    plan[SLOT_A_TAIL0] = final_r && (m >= 2'd2) && (sa == 2'd1);
    plan[SLOT_B_TAIL0] = final_r && (m >= 2'd2) && (sb == 2'd1);
    plan[SLOT_LAST]    = final_r;
  end

  assign lowest = pend_r & (~pend_r + NUM_SLOTS'(1));

  always_comb begin
    cur_slot = SLOT_FIRST;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        cur_slot = 3'(i);
      end
    end
  end

  always_comb begin
    job_pass = 1'b0;
    job_b    = 1'b0;
    job_d    = 2'd0;
    case (cur_slot) inside
      SLOT_FIRST, SLOT_LAST: job_pass = 1'b1;
      SLOT_A_MAIN:           job_d = m - 2'd1;
      SLOT_B_MAIN: begin
        job_b = 1'b1;
        job_d = m - 2'd1;
      end
      SLOT_A_TAIL1:          job_d = 2'd1;
      SLOT_B_TAIL1: begin
        job_b = 1'b1;
        job_d = 2'd1;
      end
      SLOT_A_TAIL0:          job_d = 2'd0;
      SLOT_B_TAIL0:          job_b = 1'b1;
      default:               job_pass = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    final_nxt = final_r;
    pend_nxt  = pend_r;
    sel_b_nxt = sel_b_r;
    d_nxt     = d_r;
    u_nxt     = u_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_point = 1'b1;
          first_nxt      = (status.seen_clip == 2'd0);
          final_nxt      = in_final;
          state_nxt      = S_PLAN;
        end
      end
      S_PLAN: begin
        pend_nxt  = plan;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (pend_r == '0) begin
          state_nxt = S_IDLE;
        end else if (job_pass) begin
          if (status.out_free) begin
            cmd.out_pass = 1'b1;
            cmd.run_end  = (cur_slot == SLOT_LAST);
            cmd.end_net  = (cur_slot == SLOT_LAST);
            pend_nxt     = pend_r & ~lowest;
          end
        end else begin
          cmd.mac_clear = 1'b1;
          pend_nxt      = pend_r & ~lowest;
          sel_b_nxt     = job_b;
          d_nxt         = job_d;
          u_nxt         = job_b ? ub : ua;
          k_nxt         = 2'd0;
          state_nxt     = ((job_b ? ub : ua) == '0) ? S_DIVGO : S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        cmd.sel_b    = sel_b_r;
        cmd.tap_k    = k_r;
        cmd.win_pos  = d_r - k_r;
        if (k_r == u_r - 2'd1) begin
          state_nxt = S_DIVGO;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      S_DIVGO: begin
        if (status.den_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!status.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_result = 1'b1;
          state_nxt      = S_PICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      final_r <= 1'b0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_b_r <= sel_b_nxt;
    d_r     <= d_nxt;
    u_r     <= u_nxt;
    k_r     <= k_nxt;
  end

  a_tap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (k_r < u_r))
    else $error("tap counter ran past the stencil length");

  a_idle_no_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pend_r == '0))
    else $error("new point taken with result jobs still pending");

endmodule

// ===== hdl/stencil_curve_subdivision_core.sv =====
// A point is taken in S_IDLE and planned in S_PLAN; S_PICK then loads a pass-through first result
// into the output register once it is free. Each stencil result runs a tap-serial MAC, then a
// one-bit-per-cycle restoring divider; a saturating quotient or a zero tap sum skips the divide
// loop. A new point is taken only once every result of the last one is in the output register.
// Reset (rst_n low, synchronous): registers return to their defaults, the net count clears and
// the output channel empties; window contents are not cleared since they are never read unfilled.
module stencil_curve_subdivision_core import scs_pkg::*; #(
  parameter int MAX_TAPS    = SCS_MAX_TAPS,
  parameter int COORD_WIDTH = SCS_COORD_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  scs_point_if.sink      in_if,
  scs_result_if.source   out_if,
  scs_cfg_if.sink        cfg_if
);

  // Stencil configuration. Writes are accepted every cycle; the index
  // field covers exactly the eight registers, so every write lands.
  scs_stencil_t cfg_a_r, cfg_a_nxt;
  scs_stencil_t cfg_b_r, cfg_b_nxt;

  scs_cmd_t     cmd;
  scs_status_t  status;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_a_nxt = cfg_a_r;
    cfg_b_nxt = cfg_b_r;
    if (cfg_if.valid && cfg_if.ready) begin
      unique case (scs_reg_idx_t'(cfg_if.index))
        REG_A_TAP_FIRST:  cfg_a_nxt.taps[0] = cfg_if.data;
        REG_A_TAP_SECOND: cfg_a_nxt.taps[1] = cfg_if.data;
        REG_A_TAP_THIRD:  cfg_a_nxt.taps[2] = cfg_if.data;
        REG_A_LENGTH:     cfg_a_nxt.len     = cfg_if.data[LEN_W-1:0];
        REG_B_TAP_FIRST:  cfg_b_nxt.taps[0] = cfg_if.data;
        REG_B_TAP_SECOND: cfg_b_nxt.taps[1] = cfg_if.data;
        REG_B_TAP_THIRD:  cfg_b_nxt.taps[2] = cfg_if.data;
        REG_B_LENGTH:     cfg_b_nxt.len     = cfg_if.data[LEN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_a_r <= RST_STENCIL_A;
      cfg_b_r <= RST_STENCIL_B;
    end else begin
      cfg_a_r <= cfg_a_nxt;
      cfg_b_r <= cfg_b_nxt;
    end
  end

  // The controller takes one point transaction at a time, plans the list
  // of results it causes (first point, the two full stencils, the flushed
  // partial windows and the last point) and walks the datapath through it.
  scs_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_final (in_if.final_point),
    .in_ready (in_if.ready),
    .len_a    (cfg_a_r.len),
    .len_b    (cfg_b_r.len),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the point window, the multiply-accumulate, two
  // dividers for x and y, and the output register that lets a finished
  // result wait while the next one is being computed.
  scs_dp #(.MAX_TAPS(MAX_TAPS), .COORD_WIDTH(COORD_WIDTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .taps_a       (cfg_a_r.taps),
    .taps_b       (cfg_b_r.taps),
    .in_point_x   (in_if.point_x),
    .in_point_y   (in_if.point_y),
    .out_ready    (out_if.ready),
    .out_valid    (out_if.valid),
    .out_x        (out_if.out_x),
    .out_y        (out_if.out_y),
    .out_zero_sum (out_if.zero_sum),
    .out_run_end  (out_if.run_end)
  );

endmodule

// ===== tb/tb.sv =====
module tb;
  import scs_pkg::*;

  localparam int  NET_MAX      = SCS_MAX_TAPS;
  localparam int  CW           = SCS_COORD_WIDTH;
  localparam int  MAX_REFINED  = 6;
  // A non-final point with a short window gives no result, yet the core may still be
  // busy with it. This pause covers a full point with both stencils and some margin.
  localparam int  SETTLE_CYCLES = 150;
  localparam int  CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 zero_sum;
    logic                 run_end;
  } refined_t;

  logic clk;
  logic rst_n;

  scs_point_if  #(.COORD_WIDTH(CW)) point_ch ();
  scs_result_if #(.COORD_WIDTH(CW)) refined_ch ();
  scs_cfg_if                        reg_ch ();

  stencil_curve_subdivision_core #(
    .MAX_TAPS    (NET_MAX),
    .COORD_WIDTH (CW)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (point_ch),
    .out_if (refined_ch),
    .cfg_if (reg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the stencil registers, as the core should hold them.
  logic [TAP_W-1:0] tap_reg [2][STENCIL_TAPS];
  logic [LEN_W-1:0] len_reg [2];

  // Shadow copy of the point window; index 0 holds the newest point.
  longint recent_x [NET_MAX];
  longint recent_y [NET_MAX];
  int     net_count;

  refined_t pending_refined [$];
  int       refined_this_point;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int points_sent;
  int refined_checked;
  int reg_writes;
  int zero_sum_seen;
  int cycle_count;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Prediction of the refined points.
  // ---------------------------------------------------------------------------

  function automatic void clear_prediction();
    for (int k = 0; k < STENCIL_TAPS; k++) begin
      tap_reg[0][k] = RST_STENCIL_A.taps[k];
      tap_reg[1][k] = RST_STENCIL_B.taps[k];
    end
    len_reg[0] = RST_STENCIL_A.len;
    len_reg[1] = RST_STENCIL_B.len;
    for (int i = 0; i < NET_MAX; i++) begin
      recent_x[i] = 0;
      recent_y[i] = 0;
    end
    net_count = 0;
  endfunction

  function automatic int taps_used(input int s);
    int n;
    n = int'(len_reg[s]);
    return (n > NET_MAX) ? NET_MAX : n;
  endfunction

  // A stencil without taps still occupies one window slot.
  function automatic int stencil_span(input int s);
    return (taps_used(s) == 0) ? 1 : taps_used(s);
  endfunction

  function automatic void push_refined(input longint x, input longint y,
                                       input logic zs, input logic re);
    refined_t r;
    if (refined_this_point < MAX_REFINED) begin
      r.x        = x[CW-1:0];
      r.y        = y[CW-1:0];
      r.zero_sum = zs;
      r.run_end  = re;
      pending_refined.insert(pending_refined.size(), r);
      refined_this_point++;
    end
  endfunction

  // Rounded to nearest with ties away from zero, then clipped to the coordinate range.
  function automatic longint div_round_sat(input longint num, input longint den);
    bit     neg;
    longint an;
    longint ad;
    longint q;
    longint lim;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (an + ad / 2) / ad;
    lim = longint'(1) << (CW - 1);
    if (neg) begin
      if (q > lim) q = lim;
      return -q;
    end
    if (q > lim - 1) q = lim - 1;
    return q;
  endfunction

  // Stencil s applied to the window that starts d points back from the newest point.
  function automatic void apply_stencil(input int s, input int d);
    longint nx;
    longint ny;
    longint den;
    longint w;
    int     b;
    nx  = 0;
    ny  = 0;
    den = 0;
    for (int k = 0; k < taps_used(s); k++) begin
      w = longint'($signed(tap_reg[s][k]));
      b = d - k;
      if (b < 0 || b >= NET_MAX) continue;
      nx  += recent_x[b] * w;
      ny  += recent_y[b] * w;
      den += w;
    end
    if (den == 0) begin
      push_refined(0, 0, 1'b1, 1'b0);
    end else begin
      push_refined(div_round_sat(nx, den), div_round_sat(ny, den), 1'b0, 1'b0);
    end
  endfunction

  function automatic void refine_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                       input logic is_last);
    bit opening;
    int sa;
    int sb;
    int span;
    int dd;
    refined_this_point = 0;
    opening = (net_count == 0);
    for (int i = NET_MAX - 1; i > 0; i--) begin
      recent_x[i] = recent_x[i-1];
      recent_y[i] = recent_y[i-1];
    end
    recent_x[0] = longint'($signed(px));
    recent_y[0] = longint'($signed(py));
    if (net_count < NET_MAX) net_count++;

    if (opening) push_refined(recent_x[0], recent_y[0], 1'b0, 1'b0);

    sa   = stencil_span(0);
    sb   = stencil_span(1);
    span = (sa > sb) ? sa : sb;
    if (net_count >= span) begin
      apply_stencil(0, span - 1);
      apply_stencil(1, span - 1);
    end

    if (is_last) begin
      // Flush the windows that only part of the stencils still fit into.
      for (int d = span - 1; d > 0; d--) begin
        dd = d - 1;
        if (dd >= net_count) continue;
        if (sa <= dd + 1) apply_stencil(0, dd);
        if (sb <= dd + 1) apply_stencil(1, dd);
      end
      push_refined(recent_x[0], recent_y[0], 1'b0, 1'b1);
      for (int i = 0; i < NET_MAX; i++) begin
        recent_x[i] = 0;
        recent_y[i] = 0;
      end
      net_count = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Every accepted refined point is matched against the oldest
  // prediction. The receiver stalls at random, as the current phase asks.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_refined
    refined_t want;
    if (rst_n && refined_ch.valid && refined_ch.ready) begin
      if (pending_refined.size() == 0) begin
        report_mismatch($sformatf("unexpected refined point x=%0d y=%0d",
                                  refined_ch.out_x, refined_ch.out_y));
      end else begin
        want = pending_refined.pop_front();
        refined_checked++;
        if (want.zero_sum) zero_sum_seen++;
        if (refined_ch.out_x !== want.x)
          report_mismatch($sformatf("out_x %0d, expected %0d", refined_ch.out_x, want.x));
        if (refined_ch.out_y !== want.y)
          report_mismatch($sformatf("out_y %0d, expected %0d", refined_ch.out_y, want.y));
        if (refined_ch.zero_sum !== want.zero_sum)
          report_mismatch($sformatf("zero_sum %b, expected %b",
                                    refined_ch.zero_sum, want.zero_sum));
        if (refined_ch.run_end !== want.run_end)
          report_mismatch($sformatf("run_end %b, expected %b",
                                    refined_ch.run_end, want.run_end));
      end
    end
    refined_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d refined points outstanding", pending_refined.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. The point driver never lowers valid right after a transaction; the
  // next call keeps it high, or an idle gap or drain_core lowers it, so valid sees a single
  // update per edge.
  // ---------------------------------------------------------------------------

  task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                            input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
    end
    point_ch.valid       <= 1'b1;
    point_ch.point_x     <= px;
    point_ch.point_y     <= py;
    point_ch.final_point <= is_last;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    refine_point(px, py, is_last);
    points_sent++;
  endtask

  // Hold off the input until every predicted point is back and the core has
  // had time to finish any point that produced nothing.
  task automatic drain_core();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_refined.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input scs_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= value;
    @(posedge clk);
    while (!reg_ch.ready) @(posedge clk);
    case (idx)
      REG_A_TAP_FIRST:  tap_reg[0][0] = value;
      REG_A_TAP_SECOND: tap_reg[0][1] = value;
      REG_A_TAP_THIRD:  tap_reg[0][2] = value;
      REG_A_LENGTH:     len_reg[0]    = value[LEN_W-1:0];
      REG_B_TAP_FIRST:  tap_reg[1][0] = value;
      REG_B_TAP_SECOND: tap_reg[1][1] = value;
      REG_B_TAP_THIRD:  tap_reg[1][2] = value;
      REG_B_LENGTH:     len_reg[1]    = value[LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Reprogram both stencils once the core is quiet. Lengths are passed as a full
  // data byte so that the unused upper bits get exercised too.
  task automatic set_stencils(input logic [7:0] a0, input logic [7:0] a1,
                              input logic [7:0] a2, input logic [7:0] alen,
                              input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] blen);
    drain_core();
    write_reg(REG_A_TAP_FIRST,  a0);
    write_reg(REG_A_TAP_SECOND, a1);
    write_reg(REG_A_TAP_THIRD,  a2);
    write_reg(REG_A_LENGTH,     alen);
    write_reg(REG_B_TAP_FIRST,  b0);
    write_reg(REG_B_TAP_SECOND, b1);
    write_reg(REG_B_TAP_THIRD,  b2);
    write_reg(REG_B_LENGTH,     blen);
    reg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random content.
  // ---------------------------------------------------------------------------

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return CW'(int'($urandom_range(0, 8192)) - 4096);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return CW'($urandom);
    endcase
  endfunction

  // Mostly the documented tap range, sometimes its edges, sometimes any byte.
  function automatic logic [7:0] rand_tap();
    case ($urandom_range(0, 6))
      0:       return 8'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 8'(-64);
          1:       return 8'd64;
          2:       return 8'h80;
          default: return 8'h7F;
        endcase
      end
      default: return 8'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic logic [7:0] rand_len();
    logic [7:0] v;
    v = 8'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) v[7:LEN_W] = 6'($urandom);
    return v;
  endfunction

  task automatic random_stencils();
    logic [7:0] a [3];
    logic [7:0] b [3];
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_tap();
      b[k] = rand_tap();
    end
    // Opposite taps zero the sum of a two-tap A; a balancing third tap, of a three-tap B.
    if ($urandom_range(0, 4) == 0) a[1] = -a[0];
    if ($urandom_range(0, 4) == 0) b[2] = -(b[0] + b[1]);
    set_stencils(a[0], a[1], a[2], rand_len(), b[0], b[1], b[2], rand_len());
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset stencils: a four-point net, then a single-point net, then a new net
  // straight after a final point.
  task automatic test_reset_stencils();
    send_point(16'sh1000, 16'sh2000, 1'b0);
    send_point(-16'sh1000, 16'sh0800, 1'b0);
    send_point(16'sh3000, -16'sh3000, 1'b0);
    send_point(16'sh0400, 16'sh0400, 1'b1);
    send_point(16'sh0123, -16'sh0456, 1'b1);
    send_point(16'sh1000, 16'sh1000, 1'b0);
    send_point(16'sh2000, 16'sh0000, 1'b1);
  endtask

  // Full-scale coordinates through large weights of both signs.
  task automatic test_coord_extremes();
    set_stencils(-8'sd64, -8'sd64, 8'd0, 8'd2, 8'd64, 8'd64, 8'd64, 8'd3);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
  endtask

  // A zero tap sum, quotients far past the coordinate range, and taps
  // outside the documented range taken as raw bytes.
  task automatic test_zero_sum_and_clipping();
    set_stencils(8'd1, -8'sd1, 8'd0, 8'd2, 8'd64, -8'sd63, 8'd0, 8'd2);
    send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sd100, -16'sd100, 1'b1);
    set_stencils(8'h80, 8'h7F, 8'd0, 8'd2, 8'h7F, 8'h7F, 8'h80, 8'd3);
    send_point(16'sh7FFF, 16'sd1000, 1'b0);
    send_point(16'sh8000, -16'sd1000, 1'b0);
    send_point(16'sd5, -16'sd5, 1'b1);
  endtask

  // Halfway quotients of both signs, and stencils of length zero.
  task automatic test_rounding_and_empty_stencil();
    set_stencils(8'd1, 8'd1, 8'd0, 8'd2, 8'd3, 8'd0, 8'd0, 8'd0);
    send_point(16'sd1, -16'sd1, 1'b0);
    send_point(16'sd2, -16'sd2, 1'b0);
    send_point(-16'sd7, 16'sd6, 1'b1);
    set_stencils(8'd3, 8'd5, 8'd7, 8'hFD, 8'd9, 8'd2, 8'd1, 8'hFC);
    send_point(16'sd5, -16'sd5, 1'b1);
    send_point(16'sd30, 16'sd31, 1'b0);
    send_point(-16'sd29, 16'sd4, 1'b1);
  endtask

  // Random nets of one to six points under random stencils. Now and then the
  // sender waits for the core to empty before the next point.
  task automatic test_random_nets(input int items, input int send_pct, input int recv_pct);
    int sent;
    int net_len;
    sent           = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    random_stencils();
    while (sent < items) begin
      if ($urandom_range(0, 2) == 0) random_stencils();
      net_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 6);
      for (int i = 0; i < net_len; i++) begin
        if ($urandom_range(0, 39) == 0) drain_core();
        send_point(rand_coord(), rand_coord(), i == net_len - 1);
        sent++;
      end
    end
    drain_core();
  endtask

  initial begin : stimulus
    rst_n                <= 1'b0;
    point_ch.valid       <= 1'b0;
    point_ch.point_x     <= '0;
    point_ch.point_y     <= '0;
    point_ch.final_point <= 1'b0;
    reg_ch.valid         <= 1'b0;
    reg_ch.index         <= REG_A_TAP_FIRST;
    reg_ch.data          <= '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    fail_count      = 0;
    points_sent     = 0;
    refined_checked = 0;
    reg_writes      = 0;
    zero_sum_seen   = 0;
    cycle_count     = 0;
    clear_prediction();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs without idling on either side.
    test_reset_stencils();
    test_zero_sum_and_clipping();
    test_coord_extremes();
    test_rounding_and_empty_stencil();

    test_random_nets(70, 0, 0);
    test_random_nets(70, 61, 0);
    test_random_nets(70, 0, 61);
    test_random_nets(70, 27, 27);

    drain_core();
    $display("Sent %0d control points and checked %0d refined points (%0d with a zero sum),",
             points_sent, refined_checked, zero_sum_seen);
    $display("with %0d stencil register writes across four idle and stall mixes.", reg_writes);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
